@@ src/dmrc_pkg.sv @@
// shared types, codes and constants for the dual motor ramp controller
`timescale 1ns / 1ps

package dmrc_pkg;

  typedef enum logic [2:0] {
    MODE_STOPPED  = 3'd0,
    MODE_FORWARD  = 3'd1,
    MODE_BACKWARD = 3'd2,
    MODE_LEFT     = 3'd3,
    MODE_RIGHT    = 3'd4
  } mode_t;

  // request command codes
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_MOVE     = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_OBSTACLE = 3'd3;
  localparam logic [2:0] CMD_PING     = 3'd4;

  // move direction codes
  localparam logic [2:0] DIR_FORWARD = 3'd0;
  localparam logic [2:0] DIR_BACK    = 3'd1;
  localparam logic [2:0] DIR_LEFT    = 3'd2;
  localparam logic [2:0] DIR_RIGHT   = 3'd3;

  // register indexes
  localparam logic [2:0] REG_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd1;
  localparam logic [2:0] REG_STEP     = 3'd2;
  localparam logic [2:0] REG_LTRIM    = 3'd3;
  localparam logic [2:0] REG_RTRIM    = 3'd4;

  localparam logic [15:0] TIMEOUT_RST  = 16'd500;
  localparam logic [15:0] INTERVAL_RST = 16'd20;
  localparam logic [7:0]  STEP_RST     = 8'd10;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [7:0]  LEVEL_MAX    = 8'd255;

  // x / 100 as (x * 5243) >> 19, exact for x below 43690
  localparam int unsigned PERCENT      = 100;
  localparam int unsigned RECIP_SHIFT  = 19;
  localparam logic [12:0] RECIP        = 13'((2**RECIP_SHIFT + PERCENT - 1) / PERCENT);

  typedef struct packed {
    logic ld_mul;
    logic ld_out;
  } stage_ctrl_t;

  // bridge pins {right_in2, right_in1, left_in2, left_in1}
  function automatic logic [3:0] dir_pins(mode_t m);
    logic [3:0] p;
    case (m)
      MODE_FORWARD:  p = 4'b0101;
      MODE_BACKWARD: p = 4'b1010;
      MODE_LEFT:     p = 4'b0110;
      MODE_RIGHT:    p = 4'b1001;
      default:       p = 4'b0000;
    endcase
    return p;
  endfunction

endpackage

@@ src/dmrc_trim.sv @@
// per-side percent trim and clamp, two register stages
`timescale 1ns / 1ps

module dmrc_trim (
  input  logic                clk,
  input  dmrc_pkg::stage_ctrl_t ctrl,
  input  logic [7:0]          level,
  input  logic signed [7:0]   trim,
  output logic [7:0]          duty
);
  import dmrc_pkg::*;

  logic [7:0]         mag;
  logic [15:0]        prod_full;
  logic [14:0]        prod_r;
  logic [7:0]         lvl_r;
  logic               neg_r;
  logic [27:0]        quo_full;
  logic [8:0]         quo;
  logic signed [10:0] sum;
  logic [7:0]         duty_nxt;
  logic [7:0]         duty_r;
  logic [7:0]         trim_u;

  assign trim_u    = trim;
  assign mag       = trim_u[7] ? (~trim_u + 8'd1) : trim_u;
  assign prod_full = {8'd0, level} * {8'd0, mag};

  // stage one: level times trim magnitude
  always_ff @(posedge clk) begin
    if (ctrl.ld_mul) begin
      prod_r <= prod_full[14:0];
      lvl_r  <= level;
      neg_r  <= trim_u[7];
    end
  end

  // stage two: divide by 100 (toward zero), add and clamp
  always_comb begin
    quo_full = {13'd0, prod_r} * {15'd0, RECIP};
    quo      = quo_full[27:19];
    if (neg_r) begin
      sum = $signed({3'd0, lvl_r}) - $signed({2'd0, quo});
    end else begin
      sum = $signed({3'd0, lvl_r}) + $signed({2'd0, quo});
    end
    if (sum < 0) begin
      duty_nxt = 8'd0;
    end else if (sum > $signed({3'd0, LEVEL_MAX})) begin
      duty_nxt = LEVEL_MAX;
    end else begin
      duty_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      duty_r <= duty_nxt;
    end
  end

  assign duty = duty_r;

endmodule

@@ src/dual_motor_ramp_controller_core.sv @@
// top level of the dual motor soft-start ramp controller
`timescale 1ns / 1ps
// throughput: one request per cycle unless out_ready stalls the output;
//   stages are input register, state update, trim multiply, reciprocal
//   divide and clamp into the output register
// reset (rst_n low, synchronous): pipeline empty, modes stopped, levels
//   and counters zero, registers back to their defaults

module dual_motor_ramp_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_direction,
  input  logic [7:0]  in_speed,
  input  logic        in_obstacle_flag,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_left_in1,
  output logic        out_left_in2,
  output logic        out_right_in1,
  output logic        out_right_in2,
  output logic [7:0]  out_left_duty,
  output logic [7:0]  out_right_duty,
  output logic        out_driver_enable,
  output logic [2:0]  out_motion_state,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dmrc_pkg::*;

  // ---------------- register file ----------------
  logic [15:0]       timeout_r;
  logic [15:0]       interval_r;
  logic [7:0]        step_r;
  logic signed [7:0] ltrim_r;
  logic signed [7:0] rtrim_r;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      interval_r <= INTERVAL_RST;
      step_r     <= STEP_RST;
      ltrim_r    <= '0;
      rtrim_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TIMEOUT:  timeout_r  <= pwdata[15:0];
        REG_INTERVAL: interval_r <= pwdata[15:0];
        REG_STEP:     step_r     <= pwdata[7:0];
        REG_LTRIM:    ltrim_r    <= pwdata[7:0];
        REG_RTRIM:    rtrim_r    <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT:  prdata = {16'd0, timeout_r};
      REG_INTERVAL: prdata = {16'd0, interval_r};
      REG_STEP:     prdata = {24'd0, step_r};
      REG_LTRIM:    prdata = {24'd0, ltrim_r};
      REG_RTRIM:    prdata = {24'd0, rtrim_r};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  // each stage moves on when the next one is empty or moving
  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic ld1, ld2, ld3;
  logic in_fire;
  stage_ctrl_t trim_ctrl;

  assign rdy3     = !v3_r || out_ready;
  assign ld3      = v2_r && rdy3;
  assign rdy2     = !v2_r || rdy3;
  assign ld2      = v1_r && rdy2;
  assign rdy1     = !v1_r || rdy2;
  assign ld1      = v0_r && rdy1;
  assign in_ready = !v0_r || rdy1;
  assign in_fire  = in_valid && in_ready;

  assign trim_ctrl.ld_mul = ld2;
  assign trim_ctrl.ld_out = ld3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= in_fire || (v0_r && !ld1);
      v1_r <= ld1 || (v1_r && !ld2);
      v2_r <= ld2 || (v2_r && !ld3);
      v3_r <= ld3 || (v3_r && !out_ready);
    end
  end

  // input register
  logic [2:0] cmd_r, dir_r;
  logic [7:0] spd_r;
  logic       flag_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_cmd;
      dir_r  <= in_direction;
      spd_r  <= in_speed;
      flag_r <= in_obstacle_flag;
    end
  end

  // ---------------- motion state ----------------
  // pins and duties are a pure function of the last driven mode, level and trims, so
  // the state keeps those instead of the pin word
  mode_t             tgt_r, act_r, pmode_r;
  logic [7:0]        tlvl_r, cur_r, plvl_r;
  logic signed [7:0] pltrim_r, prtrim_r;
  logic              obst_r;
  logic [15:0]       since_cmd_r, since_ramp_r;

  mode_t             tgt_nxt, act_nxt, pmode_nxt, drv_mode, mv_mode;
  logic [7:0]        tlvl_nxt, cur_nxt, plvl_nxt;
  logic signed [7:0] pltrim_nxt, prtrim_nxt;
  logic              obst_nxt;
  logic [15:0]       since_cmd_nxt, since_ramp_nxt;
  logic              mv_ok;

  always_comb begin
    tgt_nxt        = tgt_r;
    act_nxt        = act_r;
    pmode_nxt      = pmode_r;
    tlvl_nxt       = tlvl_r;
    cur_nxt        = cur_r;
    plvl_nxt       = plvl_r;
    pltrim_nxt     = pltrim_r;
    prtrim_nxt     = prtrim_r;
    obst_nxt       = obst_r;
    since_cmd_nxt  = since_cmd_r;
    since_ramp_nxt = since_ramp_r;
    drv_mode       = MODE_STOPPED;
    mv_mode        = MODE_STOPPED;
    mv_ok          = 1'b1;

    case (cmd_r)
      CMD_TICK: begin
        if (since_cmd_r != COUNT_MAX) since_cmd_nxt = since_cmd_r + 16'd1;
        if (since_ramp_r != COUNT_MAX) since_ramp_nxt = since_ramp_r + 16'd1;
        // command timeout, or forward motion into a latched obstacle
        if ((tgt_r != MODE_STOPPED && since_cmd_nxt > timeout_r) ||
            (obst_r && tgt_r == MODE_FORWARD)) begin
          tgt_nxt   = MODE_STOPPED;
          act_nxt   = MODE_STOPPED;
          tlvl_nxt  = 8'd0;
          cur_nxt   = 8'd0;
          pmode_nxt = MODE_STOPPED;
          plvl_nxt  = 8'd0;
        end
        if (since_ramp_nxt >= interval_r) begin
          since_ramp_nxt = 16'd0;
          if (tgt_nxt != act_nxt && cur_nxt != 8'd0) begin
            // wind down in the old direction first
            cur_nxt  = (cur_nxt > step_r) ? (cur_nxt - step_r) : 8'd0;
            drv_mode = act_nxt;
          end else begin
            act_nxt = tgt_nxt;
            if (cur_nxt < tlvl_nxt) begin
              cur_nxt = ((tlvl_nxt - cur_nxt) > step_r) ? (cur_nxt + step_r) : tlvl_nxt;
            end else if (cur_nxt > tlvl_nxt) begin
              cur_nxt = ((cur_nxt - tlvl_nxt) > step_r) ? (cur_nxt - step_r) : tlvl_nxt;
            end
            drv_mode = act_nxt;
          end
          if (drv_mode == MODE_STOPPED) begin
            tgt_nxt   = MODE_STOPPED;
            act_nxt   = MODE_STOPPED;
            tlvl_nxt  = 8'd0;
            cur_nxt   = 8'd0;
            pmode_nxt = MODE_STOPPED;
            plvl_nxt  = 8'd0;
          end else begin
            // duties keep the trims in force when the pins were driven
            pmode_nxt  = drv_mode;
            plvl_nxt   = cur_nxt;
            pltrim_nxt = ltrim_r;
            prtrim_nxt = rtrim_r;
          end
        end
      end
      CMD_MOVE: begin
        unique case (dir_r)
          DIR_FORWARD: mv_mode = MODE_FORWARD;
          DIR_BACK:    mv_mode = MODE_BACKWARD;
          DIR_LEFT:    mv_mode = MODE_LEFT;
          DIR_RIGHT:   mv_mode = MODE_RIGHT;
          default:     mv_ok   = 1'b0;
        endcase
        if (!mv_ok || (mv_mode == MODE_FORWARD && obst_r)) begin
          tgt_nxt   = MODE_STOPPED;
          act_nxt   = MODE_STOPPED;
          tlvl_nxt  = 8'd0;
          cur_nxt   = 8'd0;
          pmode_nxt = MODE_STOPPED;
          plvl_nxt  = 8'd0;
        end else begin
          tgt_nxt       = mv_mode;
          tlvl_nxt      = spd_r;
          since_cmd_nxt = 16'd0;
          if (act_r == MODE_STOPPED) act_nxt = mv_mode;
        end
      end
      CMD_OBSTACLE: begin
        // rising obstacle while heading forward
        if (flag_r && !obst_r && (tgt_r == MODE_FORWARD || act_r == MODE_FORWARD)) begin
          tgt_nxt   = MODE_STOPPED;
          act_nxt   = MODE_STOPPED;
          tlvl_nxt  = 8'd0;
          cur_nxt   = 8'd0;
          pmode_nxt = MODE_STOPPED;
          plvl_nxt  = 8'd0;
        end
        obst_nxt = flag_r;
      end
      CMD_PING: ;
      default: begin
        // stop request and invalid codes
        tgt_nxt   = MODE_STOPPED;
        act_nxt   = MODE_STOPPED;
        tlvl_nxt  = 8'd0;
        cur_nxt   = 8'd0;
        pmode_nxt = MODE_STOPPED;
        plvl_nxt  = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r        <= MODE_STOPPED;
      act_r        <= MODE_STOPPED;
      pmode_r      <= MODE_STOPPED;
      tlvl_r       <= '0;
      cur_r        <= '0;
      plvl_r       <= '0;
      pltrim_r     <= '0;
      prtrim_r     <= '0;
      obst_r       <= 1'b0;
      since_cmd_r  <= '0;
      since_ramp_r <= '0;
    end else if (ld1) begin
      tgt_r        <= tgt_nxt;
      act_r        <= act_nxt;
      pmode_r      <= pmode_nxt;
      tlvl_r       <= tlvl_nxt;
      cur_r        <= cur_nxt;
      plvl_r       <= plvl_nxt;
      pltrim_r     <= pltrim_nxt;
      prtrim_r     <= prtrim_nxt;
      obst_r       <= obst_nxt;
      since_cmd_r  <= since_cmd_nxt;
      since_ramp_r <= since_ramp_nxt;
    end
  end

  // ---------------- result stages ----------------
  mode_t             s1_pmode_r, s2_pmode_r;
  logic [7:0]        s1_plvl_r;
  logic signed [7:0] s1_ltrim_r, s1_rtrim_r;
  mode_t             s1_motion_r, s2_motion_r;
  logic [3:0]        pins_r;
  logic [2:0]        motion_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_pmode_r  <= pmode_nxt;
      s1_plvl_r   <= plvl_nxt;
      s1_ltrim_r  <= pltrim_nxt;
      s1_rtrim_r  <= prtrim_nxt;
      s1_motion_r <= act_nxt;
    end
    if (ld2) begin
      s2_pmode_r  <= s1_pmode_r;
      s2_motion_r <= s1_motion_r;
    end
    if (ld3) begin
      pins_r   <= dir_pins(s2_pmode_r);
      motion_r <= s2_motion_r;
    end
  end

  // a stopped pin state always carries level zero, so duties come out zero
  dmrc_trim u_trim_left (
    .clk   (clk),
    .ctrl  (trim_ctrl),
    .level (s1_plvl_r),
    .trim  (s1_ltrim_r),
    .duty  (out_left_duty)
  );

  dmrc_trim u_trim_right (
    .clk   (clk),
    .ctrl  (trim_ctrl),
    .level (s1_plvl_r),
    .trim  (s1_rtrim_r),
    .duty  (out_right_duty)
  );

  assign out_valid         = v3_r;
  assign out_left_in1      = pins_r[0];
  assign out_left_in2      = pins_r[1];
  assign out_right_in1     = pins_r[2];
  assign out_right_in2     = pins_r[3];
  assign out_driver_enable = (out_left_duty != 8'd0) || (out_right_duty != 8'd0);
  assign out_motion_state  = motion_r;

  // ---------------- assertions ----------------
  // an idle bridge has no speed and no driven pins
  a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r == MODE_STOPPED) |-> (cur_r == 8'd0 && pmode_r == MODE_STOPPED))
    else $error("active mode stopped with nonzero level or driven pins");

  // a stopped target carries no target speed
  a_target_level: assert property (@(posedge clk) disable iff (!rst_n)
    (tgt_r == MODE_STOPPED) |-> (tlvl_r == 8'd0))
    else $error("stopped target with nonzero target level");

  // latched obstacle never leaves forward as target
  a_obstacle_block: assert property (@(posedge clk) disable iff (!rst_n)
    obst_r |-> (tgt_r != MODE_FORWARD))
    else $error("forward target while obstacle latched");

  // stopped pins mean a zero pin level
  a_pin_level: assert property (@(posedge clk) disable iff (!rst_n)
    (pmode_r == MODE_STOPPED) |-> (plvl_r == 8'd0))
    else $error("stopped pins with nonzero level");

  // state only moves when a request leaves the input register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ld1 |=> ($stable(cur_r) && $stable(act_r) && $stable(since_cmd_r)))
    else $error("motion state changed without a request");

endmodule
